[rtl/adsr_pkg.sv]
// Shared types and constants for the ADSR envelope level block.
// Used by the channel interfaces and every rtl module; depends on nothing.
package adsr_pkg;

   localparam int CNT_W   = 24;  // count field width (time, duration, lengths)
   localparam int LEVEL_W = 25;  // signed Q8.16 level
   localparam int PHASE_W = 3;
   localparam int FACT_W  = 26;  // signed release factor
   localparam int DEN_W   = 25;  // divisor width (length + 1)
   localparam int QUO_W   = 25;  // quotient bits before saturation
   localparam int NUM_W   = 51;  // numerator magnitude, covers FRAC_BITS up to 24
   localparam int CSR_IDX_W = 3;

   localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 25'sh0FFFFFF;
   localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 25'sh1000000;

   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK    = 3'd4;

   typedef enum logic [PHASE_W-1:0] {
      PH_ATTACK  = 3'd0,
      PH_DECAY   = 3'd1,
      PH_FADE    = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4
   } phase_type;

   typedef struct packed {
      logic [CNT_W-1:0] attack_len;
      logic [CNT_W-1:0] decay_len;
      logic [CNT_W-1:0] release_len;
      logic [CNT_W-1:0] fade_limit;
      logic [CNT_W-1:0] peak_gain;
   } cfg_type;

   // Per-item data that rides alongside the dividers
   typedef struct packed {
      logic                     rel;
      phase_type                phase;
      logic signed [FACT_W-1:0] factor;
      logic [CNT_W-1:0]         total;
   } tag_type;

endpackage

[rtl/adsr_if.sv]
// Valid/ready channel interfaces for request and response items.
// Depends on adsr_pkg for field widths.
interface adsr_req_if import adsr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] sample_index;
   logic [CNT_W-1:0] note_duration;

   modport source (output valid, output sample_index, output note_duration, input ready);
   modport sink   (input valid, input sample_index, input note_duration, output ready);
endinterface

interface adsr_rsp_if import adsr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [LEVEL_W-1:0] level;
   logic [PHASE_W-1:0]        phase;
   logic [CNT_W-1:0]          total_length;

   modport source (output valid, output level, output phase, output total_length, input ready);
   modport sink   (input valid, input level, input phase, input total_length, output ready);
endinterface

[rtl/adsr_front.sv]
// Front pipeline: decode time against the note, classify the phase, form the
// level numerator and divisor. Six register stages. Depends on adsr_pkg.
module adsr_front import adsr_pkg::*; #(
   parameter int COUNT_WIDTH = 24,
   parameter int FRAC_BITS   = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  cfg_type             cfg,
   input  logic                in_valid,
   input  logic [CNT_W-1:0]    in_index,
   input  logic [CNT_W-1:0]    in_duration,
   output logic                out_valid,
   output logic                out_neg,
   output logic [NUM_W-1:0]    out_mag,
   output logic [DEN_W-1:0]    out_den,
   output tag_type             out_tag
);

   localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
   localparam logic [CNT_W-1:0] CNT_MASK = COUNT_MAX[CNT_W-1:0];
   localparam int NS = NUM_W + 1;
   localparam logic signed [NS-1:0] ONE_NUM = NS'(1) <<< FRAC_BITS;
   localparam logic signed [25:0] ONE_26 = 26'sd1 <<< FRAC_BITS;

   // stage A: masked inputs
   logic             va_ff;
   logic [CNT_W-1:0] t_a_ff, dur_a_ff;
   logic [CNT_W-1:0] t_m, dur_m;

   // stage B: held time, release factor, total length
   logic             vb_ff, rel_b_ff;
   logic [CNT_W-1:0] ht_b_ff, total_b_ff;
   logic signed [FACT_W-1:0] fact_b_ff;
   logic             rel_b_in;
   logic [CNT_W-1:0] ht_b_in, total_b_in;
   logic signed [FACT_W-1:0] fact_b_in;
   logic [25:0]      cap, dur26, total_raw;

   // stage C: phase and offsets
   logic             vc_ff, rel_c_ff;
   phase_type        ph_c_ff, ph_c_in;
   logic [CNT_W:0]   htp1_c_ff, ad_sum;
   logic signed [26:0] adm_c_ff;
   logic [CNT_W-1:0] total_c_ff;
   logic signed [FACT_W-1:0] fact_c_ff;

   // stage D: products
   logic             vd_ff, rel_d_ff;
   phase_type        ph_d_ff;
   logic [48:0]      proda_d_ff;
   logic signed [52:0] prodd_d_ff;
   logic signed [27:0] left_d_ff;
   logic signed [25:0] pm1;
   logic [CNT_W-1:0] total_d_ff;
   logic signed [FACT_W-1:0] fact_d_ff;

   // stage E: signed numerator and divisor
   logic             ve_ff;
   logic signed [NS-1:0] num_e_ff, num_e_in;
   logic [DEN_W-1:0] den_e_ff, den_e_in;
   tag_type          tag_e_ff;

   // stage F: magnitude with half divisor for rounding
   logic             vf_ff, neg_f_ff;
   logic [NUM_W-1:0] mag_f_ff, mag_abs;
   logic [DEN_W-1:0] den_f_ff;
   tag_type          tag_f_ff;

   assign t_m   = in_index & CNT_MASK;
   assign dur_m = in_duration & CNT_MASK;

   // held time is the last held sample once past the duration
   always_comb begin
      rel_b_in  = t_a_ff >= dur_a_ff;
      ht_b_in   = rel_b_in ? dur_a_ff - 1'b1 : t_a_ff;
      fact_b_in = $signed({2'b00, cfg.release_len}) + $signed({2'b00, dur_a_ff})
                - $signed({2'b00, t_a_ff});
      cap       = 26'(cfg.attack_len) + 26'(cfg.decay_len) + 26'(cfg.fade_limit);
      dur26     = 26'(dur_a_ff);
      if (cfg.fade_limit != '0 && dur26 > cap) begin
         total_raw = cap;
      end else begin
         total_raw = dur26 + 26'(cfg.release_len);
      end
      total_b_in = ({6'b0, total_raw} > COUNT_MAX) ? COUNT_MAX[CNT_W-1:0]
                                                   : total_raw[CNT_W-1:0];
   end

   // classify the held time
   always_comb begin
      ad_sum = 25'(cfg.attack_len) + 25'(cfg.decay_len);
      if (ht_b_ff < cfg.attack_len) begin
         ph_c_in = PH_ATTACK;
      end else if ({1'b0, ht_b_ff} < ad_sum) begin
         ph_c_in = PH_DECAY;
      end else if (cfg.fade_limit != '0) begin
         ph_c_in = PH_FADE;
      end else begin
         ph_c_in = PH_SUSTAIN;
      end
   end

   assign pm1 = $signed({2'b00, cfg.peak_gain}) - ONE_26;

   // pick numerator and divisor per phase
   always_comb begin
      unique case (ph_d_ff)
         PH_ATTACK: begin
            num_e_in = $signed(NS'(proda_d_ff));
            den_e_in = DEN_W'(cfg.attack_len);
         end
         PH_DECAY: begin
            num_e_in = ((NS'(cfg.decay_len) + NS'(1)) <<< FRAC_BITS) + NS'(prodd_d_ff);
            den_e_in = DEN_W'(cfg.decay_len) + DEN_W'(1);
         end
         PH_FADE: begin
            num_e_in = NS'(left_d_ff) <<< FRAC_BITS;
            den_e_in = DEN_W'(cfg.fade_limit);
         end
         default: begin
            num_e_in = ONE_NUM;
            den_e_in = DEN_W'(1);
         end
      endcase
   end

   assign mag_abs = num_e_ff[NS-1] ? NUM_W'(-num_e_ff) : NUM_W'(num_e_ff);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         t_a_ff     <= t_m;
         dur_a_ff   <= (dur_m == '0) ? CNT_W'(1) : dur_m;

         rel_b_ff   <= rel_b_in;
         ht_b_ff    <= ht_b_in;
         fact_b_ff  <= fact_b_in;
         total_b_ff <= total_b_in;

         rel_c_ff   <= rel_b_ff;
         ph_c_ff    <= ph_c_in;
         htp1_c_ff  <= {1'b0, ht_b_ff} + 25'd1;
         adm_c_ff   <= $signed({2'b00, ad_sum}) - $signed({3'b000, ht_b_ff});
         total_c_ff <= total_b_ff;
         fact_c_ff  <= fact_b_ff;

         rel_d_ff   <= rel_c_ff;
         ph_d_ff    <= ph_c_ff;
         proda_d_ff <= htp1_c_ff * cfg.peak_gain;
         prodd_d_ff <= pm1 * adm_c_ff;
         left_d_ff  <= $signed({4'b0000, cfg.fade_limit}) + 28'(adm_c_ff);
         total_d_ff <= total_c_ff;
         fact_d_ff  <= fact_c_ff;

         num_e_ff   <= num_e_in;
         den_e_ff   <= den_e_in;
         tag_e_ff   <= '{rel: rel_d_ff, phase: rel_d_ff ? PH_RELEASE : ph_d_ff,
                         factor: fact_d_ff, total: total_d_ff};

         neg_f_ff   <= num_e_ff[NS-1];
         mag_f_ff   <= mag_abs + NUM_W'(den_e_ff >> 1);
         den_f_ff   <= den_e_ff;
         tag_f_ff   <= tag_e_ff;
      end
   end

   assign out_valid = vf_ff;
   assign out_neg   = neg_f_ff;
   assign out_mag   = mag_f_ff;
   assign out_den   = den_f_ff;
   assign out_tag   = tag_f_ff;

endmodule

[rtl/adsr_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with rounding
// already folded into the numerator and saturation to the level range.
// Depends on adsr_pkg.
module adsr_div import adsr_pkg::*; #(
   parameter int SW = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic                      in_neg,
   input  logic [NUM_W-1:0]          in_mag,
   input  logic [DEN_W-1:0]          in_den,
   input  logic [SW-1:0]             in_side,
   output logic                      out_valid,
   output logic signed [LEVEL_W-1:0] out_level,
   output logic [SW-1:0]             out_side
);

   localparam int RW = DEN_W + QUO_W;

   logic             v_ff    [QUO_W+1];
   logic             neg_ff  [QUO_W+1];
   logic             ovf_ff  [QUO_W+1];
   logic [RW-1:0]    rem_ff  [QUO_W+1];
   logic [QUO_W-1:0] q_ff    [QUO_W+1];
   logic [DEN_W-1:0] den_ff  [QUO_W+1];
   logic [SW-1:0]    side_ff [QUO_W+1];

   logic [RW:0]      diff    [QUO_W];
   logic [QUO_W-1:0] q_in    [QUO_W];

   logic             vo_ff;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic [SW-1:0]    side_o_ff;

   logic [NUM_W-1:0] limit;
   logic             ovf_in;

   // quotient would not fit: saturate directly
   assign limit  = NUM_W'(in_den) << QUO_W;
   assign ovf_in = in_mag >= limit;

   // one quotient bit per stage, most significant first
   always_comb begin
      for (int k = 0; k < QUO_W; k++) begin
         diff[k]                 = {1'b0, rem_ff[k]} - ((RW + 1)'(den_ff[k]) << (QUO_W - 1 - k));
         q_in[k]                 = q_ff[k];
         q_in[k][QUO_W - 1 - k]  = ~diff[k][RW];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QUO_W; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 0; k < QUO_W; k++) begin
            v_ff[k+1] <= v_ff[k];
         end
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0]  <= in_neg;
         ovf_ff[0]  <= ovf_in;
         rem_ff[0]  <= ovf_in ? '0 : in_mag[RW-1:0];
         q_ff[0]    <= '0;
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int k = 0; k < QUO_W; k++) begin
            neg_ff[k+1]  <= neg_ff[k];
            ovf_ff[k+1]  <= ovf_ff[k];
            rem_ff[k+1]  <= diff[k][RW] ? rem_ff[k] : diff[k][RW-1:0];
            q_ff[k+1]    <= q_in[k];
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   // apply sign and saturate
   always_comb begin
      if (ovf_ff[QUO_W]) begin
         level_in = neg_ff[QUO_W] ? LEVEL_MIN : LEVEL_MAX;
      end else if (neg_ff[QUO_W]) begin
         if (q_ff[QUO_W][QUO_W-1] && (q_ff[QUO_W][QUO_W-2:0] != '0)) begin
            level_in = LEVEL_MIN;
         end else begin
            level_in = $signed(LEVEL_W'(~q_ff[QUO_W]) + LEVEL_W'(1));
         end
      end else begin
         level_in = q_ff[QUO_W][QUO_W-1] ? LEVEL_MAX : $signed(LEVEL_W'(q_ff[QUO_W]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= v_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         level_ff  <= level_in;
         side_o_ff <= side_ff[QUO_W];
      end
   end

   assign out_valid = vo_ff;
   assign out_level = level_ff;
   assign out_side  = side_o_ff;

endmodule

[rtl/adsr_scale.sv]
// Release scaling: multiply the held level by the release factor and form
// the rounded numerator for the second divider. Depends on adsr_pkg.
module adsr_scale import adsr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic [CNT_W-1:0]          release_len,
   input  logic                      in_valid,
   input  logic signed [LEVEL_W-1:0] in_level,
   input  tag_type                   in_tag,
   output logic                      out_valid,
   output logic                      out_neg,
   output logic [NUM_W-1:0]          out_mag,
   output logic [DEN_W-1:0]          out_den,
   output tag_type                   out_tag
);

   localparam int PW = LEVEL_W + FACT_W;

   logic                     v1_ff, v2_ff;
   logic signed [PW-1:0]     prod_ff;
   logic [DEN_W-1:0]         den1_ff, den2_ff;
   tag_type                  tag1_ff, tag2_ff;
   logic signed [FACT_W-1:0] fact_eff;
   logic                     neg2_ff;
   logic [NUM_W-1:0]         mag2_ff, mag_abs;

   // held items pass through as level * 1 / 1
   assign fact_eff = in_tag.rel ? in_tag.factor : FACT_W'(1);
   assign mag_abs  = prod_ff[PW-1] ? NUM_W'(-prod_ff) : NUM_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= in_level * fact_eff;
         den1_ff <= in_tag.rel ? DEN_W'(release_len) + DEN_W'(1) : DEN_W'(1);
         tag1_ff <= in_tag;

         neg2_ff <= prod_ff[PW-1];
         mag2_ff <= mag_abs + NUM_W'(den1_ff >> 1);
         den2_ff <= den1_ff;
         tag2_ff <= tag1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_neg   = neg2_ff;
   assign out_mag   = mag2_ff;
   assign out_den   = den2_ff;
   assign out_tag   = tag2_ff;

endmodule

[rtl/adsr_envelope_level.sv]
// ADSR envelope level, top level. One item per cycle sustained while responses
// are taken, set by the fully pipelined front end and the two pipelined dividers;
// a full skid slot stalls the whole pipeline. Synchronous active-high reset
// clears all valid bits and loads register defaults (peak gain 1.0).
// Depends on adsr_pkg, adsr_if, adsr_front, adsr_div, adsr_scale.
module adsr_envelope_level import adsr_pkg::*; #(
   parameter int COUNT_WIDTH = 24,
   parameter int FRAC_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   adsr_req_if.sink               req,
   adsr_rsp_if.source             rsp,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CNT_W-1:0]       csr_wdata
);

   cfg_type cfg_ff;
   logic    en;

   logic             f_valid, f_neg;
   logic [NUM_W-1:0] f_mag;
   logic [DEN_W-1:0] f_den;
   tag_type          f_tag;

   logic                      d1_valid;
   logic signed [LEVEL_W-1:0] d1_level;
   tag_type                   d1_tag;

   logic             s_valid, s_neg;
   logic [NUM_W-1:0] s_mag;
   logic [DEN_W-1:0] s_den;
   tag_type          s_tag;

   logic                      d2_valid;
   logic signed [LEVEL_W-1:0] d2_level;
   tag_type                   d2_tag;

   logic                      out_v_ff, skid_v_ff;
   logic signed [LEVEL_W-1:0] out_level_ff, skid_level_ff;
   phase_type                 out_phase_ff, skid_phase_ff;
   logic [CNT_W-1:0]          out_total_ff, skid_total_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_len  <= '0;
         cfg_ff.decay_len   <= '0;
         cfg_ff.release_len <= '0;
         cfg_ff.fade_limit  <= '0;
         cfg_ff.peak_gain   <= CNT_W'(65536);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ATTACK:  cfg_ff.attack_len  <= csr_wdata;
            CSR_DECAY:   cfg_ff.decay_len   <= csr_wdata;
            CSR_RELEASE: cfg_ff.release_len <= csr_wdata;
            CSR_FADE:    cfg_ff.fade_limit  <= csr_wdata;
            CSR_PEAK:    cfg_ff.peak_gain   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline moves whenever the skid slot is free
   assign en        = ~skid_v_ff;
   assign req.ready = en;

   adsr_front #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .cfg         (cfg_ff),
      .in_valid    (req.valid),
      .in_index    (req.sample_index),
      .in_duration (req.note_duration),
      .out_valid   (f_valid),
      .out_neg     (f_neg),
      .out_mag     (f_mag),
      .out_den     (f_den),
      .out_tag     (f_tag)
   );

   adsr_div #(.SW($bits(tag_type))) u_div_held (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_neg    (f_neg),
      .in_mag    (f_mag),
      .in_den    (f_den),
      .in_side   (f_tag),
      .out_valid (d1_valid),
      .out_level (d1_level),
      .out_side  (d1_tag)
   );

   adsr_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .release_len (cfg_ff.release_len),
      .in_valid    (d1_valid),
      .in_level    (d1_level),
      .in_tag      (d1_tag),
      .out_valid   (s_valid),
      .out_neg     (s_neg),
      .out_mag     (s_mag),
      .out_den     (s_den),
      .out_tag     (s_tag)
   );

   adsr_div #(.SW($bits(tag_type))) u_div_rel (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_neg    (s_neg),
      .in_mag    (s_mag),
      .in_den    (s_den),
      .in_side   (s_tag),
      .out_valid (d2_valid),
      .out_level (d2_level),
      .out_side  (d2_tag)
   );

   // output register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp.ready) begin
            skid_v_ff <= 1'b0;
         end
      end else if (~out_v_ff || rsp.ready) begin
         out_v_ff <= d2_valid;
      end else if (d2_valid) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp.ready) begin
            out_level_ff <= skid_level_ff;
            out_phase_ff <= skid_phase_ff;
            out_total_ff <= skid_total_ff;
         end
      end else if (~out_v_ff || rsp.ready) begin
         out_level_ff <= d2_level;
         out_phase_ff <= d2_tag.phase;
         out_total_ff <= d2_tag.total;
      end else begin
         skid_level_ff <= d2_level;
         skid_phase_ff <= d2_tag.phase;
         skid_total_ff <= d2_tag.total;
      end
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.level        = out_level_ff;
   assign rsp.phase        = out_phase_ff;
   assign rsp.total_length = out_total_ff;

endmodule

[tb/adsr_envelope_level_test.sv]
// Self-checking testbench for adsr_envelope_level: random and directed sample requests,
// predicted levels, phases and note lengths checked against each response transfer.
// Depends on adsr_pkg, adsr_if and the rtl under rtl/.
`timescale 1ns / 100ps

module adsr_envelope_level_test;
   import adsr_pkg::*;

   localparam longint ONE_Q     = 65536;
   localparam longint CNT_MAX   = 64'hFFFFFF;
   localparam longint LVL_TOP   = 16777215;
   localparam longint LVL_FLOOR = -16777216;
   localparam int     DRAIN_CYCLES = 70;

   typedef struct {
      logic [CNT_W-1:0] sample_index;
      logic [CNT_W-1:0] note_duration;
   } note_sample_t;

   typedef struct {
      logic [LEVEL_W-1:0] level;
      phase_type          phase;
      logic [CNT_W-1:0]   total_length;
   } envelope_point_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ATTACK;
   logic [CNT_W-1:0]     csr_wdata = '0;

   adsr_req_if req ();
   adsr_rsp_if rsp ();

   adsr_envelope_level u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // envelope settings as the block holds them
   longint attack_len  = 0;
   longint decay_len   = 0;
   longint release_len = 0;
   longint fade_limit  = 0;
   longint peak_gain   = 65536;

   note_sample_t    sample_queue[$];
   envelope_point_t level_queue[$];
   int  error_count = 0;
   int  send_idle_pct = 22;
   int  recv_stall_pct = 45;
   bit  running = 1'b0;
   bit  took = 1'b0;

   always #10 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.sample_index = '0;
      req.note_duration = '0;
      rsp.ready = 1'b0;
   end

   // rounded quotient, clipped to the signed Q8.16 range
   function automatic longint div_round_clip(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      if (num < 0) return (q > 16777216) ? LVL_FLOOR : -q;
      return (q > LVL_TOP) ? LVL_TOP : q;
   endfunction

   function automatic longint held_level(longint t, output phase_type ph);
      longint span;
      if (t < attack_len) begin
         ph = PH_ATTACK;
         return div_round_clip((t + 1) * peak_gain, attack_len);
      end
      if (t - attack_len < decay_len) begin
         ph = PH_DECAY;
         span = decay_len - (t - attack_len);
         return div_round_clip(ONE_Q * (decay_len + 1) + (peak_gain - ONE_Q) * span,
                               decay_len + 1);
      end
      if (fade_limit > 0) begin
         ph = PH_FADE;
         return div_round_clip(ONE_Q * (fade_limit - (t - attack_len - decay_len)),
                               fade_limit);
      end
      ph = PH_SUSTAIN;
      return ONE_Q;
   endfunction

   function automatic envelope_point_t envelope_at(note_sample_t s);
      envelope_point_t p;
      longint t;
      longint dur;
      longint held;
      longint den;
      longint rel;
      longint cap;
      longint total;
      phase_type ph;
      t = s.sample_index;
      dur = (s.note_duration == 0) ? 1 : s.note_duration;
      if (t >= dur) begin
         held = held_level(dur - 1, ph);
         den = release_len + 1;
         ph = PH_RELEASE;
         p.level = LEVEL_W'(div_round_clip(held * (den - (t - dur + 1)), den));
      end else begin
         p.level = LEVEL_W'(held_level(t, ph));
      end
      p.phase = ph;
      rel = release_len;
      cap = attack_len + decay_len + fade_limit;
      if (fade_limit > 0 && dur > cap) begin
         dur = cap;
         rel = 0;
      end
      total = dur + rel;
      p.total_length = CNT_W'((total > CNT_MAX) ? CNT_MAX : total);
      return p;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
      error_count++;
   endtask

   // drive requests and response stalls
   always @(negedge clock) begin
      if (running) begin
         if (!req.valid || took) begin
            if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req.sample_index  <= sample_queue[0].sample_index;
               req.note_duration <= sample_queue[0].note_duration;
               void'(sample_queue.pop_front());
               req.valid <= 1'b1;
            end else begin
               req.valid <= 1'b0;
            end
         end
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // predict on each request transfer
   always @(posedge clock) begin
      note_sample_t s;
      took = req.valid && req.ready && !reset;
      if (took) begin
         s.sample_index  = req.sample_index;
         s.note_duration = req.note_duration;
         level_queue.push_back(envelope_at(s));
      end
   end

   // check each response transfer against the oldest prediction
   always @(posedge clock) begin
      envelope_point_t want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (level_queue.size() == 0) begin
            report_mismatch("unexpected response, level", $signed(rsp.level), 0);
         end else begin
            want = level_queue.pop_front();
            if (rsp.level !== want.level)
               report_mismatch("level", $signed(rsp.level), $signed(want.level));
            if (rsp.phase !== want.phase)
               report_mismatch("phase", rsp.phase, want.phase);
            if (rsp.total_length !== want.total_length)
               report_mismatch("total_length", rsp.total_length, want.total_length);
         end
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, longint value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CNT_W-1:0];
      case (idx)
         CSR_ATTACK:  attack_len  = value;
         CSR_DECAY:   decay_len   = value;
         CSR_RELEASE: release_len = value;
         CSR_FADE:    fade_limit  = value;
         CSR_PEAK:    peak_gain   = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_envelope(longint a, longint d, longint r, longint f, longint pk);
      csr_write(CSR_ATTACK, a);
      csr_write(CSR_DECAY, d);
      csr_write(CSR_RELEASE, r);
      csr_write(CSR_FADE, f);
      csr_write(CSR_PEAK, pk);
   endtask

   // hold until every request is taken and every response has come back
   task automatic drain(bit settle);
      while (sample_queue.size() > 0 || req.valid || level_queue.size() > 0)
         @(posedge clock);
      if (settle) repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_sample(longint t, longint dur);
      note_sample_t s;
      s.sample_index  = t[CNT_W-1:0];
      s.note_duration = dur[CNT_W-1:0];
      sample_queue.push_back(s);
   endtask

   // pick a value near one of the envelope's corners
   function automatic longint near_corner(longint dur);
      longint corners[6];
      longint v;
      corners[0] = 0;
      corners[1] = attack_len;
      corners[2] = attack_len + decay_len;
      corners[3] = attack_len + decay_len + fade_limit;
      corners[4] = dur;
      corners[5] = dur + release_len;
      v = corners[$urandom_range(5)] + $urandom_range(8) - 4;
      if (v < 0) v = 0;
      if (v > CNT_MAX) v = CNT_MAX;
      return v;
   endfunction

   task automatic add_random_samples(int count);
      longint dur;
      longint t;
      repeat (count) begin
         case ($urandom_range(9))
            0, 1: begin
               dur = $urandom_range(16777215, 1);
               t = $urandom_range(16777215);
            end
            2, 3, 4: begin
               dur = $urandom_range(200, 1);
               t = near_corner(dur);
            end
            default: begin
               dur = near_corner(0);
               if (dur == 0) dur = 1;
               t = near_corner(dur);
            end
         endcase
         add_sample(t, dur);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      running = 1'b1;

      // directed: field extremes and zero duration on reset settings
      add_sample(0, 1);
      add_sample(0, 0);
      add_sample(5, 0);
      add_sample(16777215, 16777215);
      add_sample(16777215, 1);
      add_sample(0, 16777215);
      add_sample(3, 2);
      add_random_samples(200);
      drain(1'b1);

      // small lengths and high peak; pause once until all results are back
      set_envelope(4, 3, 5, 0, 3 * 65536);
      add_sample(0, 20);
      add_sample(3, 20);
      add_sample(4, 20);
      add_sample(7, 20);
      add_sample(25, 20);
      add_sample(40, 20);
      add_random_samples(110);
      drain(1'b0);
      add_random_samples(110);
      drain(1'b1);

      // fading sustain with a peak below 1.0
      set_envelope(6, 2, 3, 10, 40000);
      add_sample(17, 30);
      add_sample(30, 30);
      add_sample(10, 15);
      add_random_samples(230);
      drain(1'b1);

      send_idle_pct = 45;
      recv_stall_pct = 22;

      // widest peak, long release
      set_envelope(0, 0, 16777215, 0, 16777215);
      add_random_samples(230);
      drain(1'b1);

      // every register at its maximum
      set_envelope(16777215, 16777215, 16777215, 16777215, 16777215);
      add_sample(16777214, 16777215);
      add_sample(16777215, 16777215);
      add_random_samples(230);
      drain(1'b1);

      // zero peak: attack stays flat at zero
      set_envelope(1, 0, 0, 1, 0);
      add_sample(0, 5);
      add_sample(1, 5);
      add_sample(9, 5);
      add_random_samples(230);
      drain(1'b1);

      send_idle_pct = 0;
      recv_stall_pct = 0;

      // high peak, and a release that runs far below zero and saturates
      set_envelope(10, 20, 7, 5, 65536 * 200);
      add_sample(100, 12);
      add_random_samples(230);
      drain(1'b1);

      // random small lengths and a random peak
      set_envelope($urandom_range(50), $urandom_range(50), $urandom_range(50),
                   $urandom_range(50), $urandom_range(16777215, 1));
      add_random_samples(300);
      drain(1'b1);

      if (error_count == 0 && level_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

endmodule
